FILE: rtl/core/kbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbpm_pkg
// shared widths, register indexes and cell control type of the binary
// pattern matcher
// ----------------------------------------------------------------------------
package kbpm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int LEN_W       = 7;
   localparam int PAT_W       = 64;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 64;
   localparam int GROUP_W     = 8;
   localparam int POS_W       = $clog2(GROUP_W);
   localparam int GROUPS      = (MAX_PATTERN + GROUP_W - 1) / GROUP_W;
   localparam int FLAGS_PAD   = GROUPS * GROUP_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BITS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

   typedef struct packed {
      logic advance;
      logic clear;
      logic symbol;
   } kbpm_cell_ctrl_type;

endpackage

FILE: rtl/core/kbpm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbpm_cell
// one position of the matcher row: flags that the pattern prefix ending at
// this position matches the text seen so far
// ----------------------------------------------------------------------------
module kbpm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  kbpm_pkg::kbpm_cell_ctrl_type ctrl,
   input  logic                        pattern_bit,
   input  logic                        enable,
   input  logic                        chain_in,
   output logic                        flag_out
);
   import kbpm_pkg::*;

   logic flag_ff;
   logic flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.clear) begin
         flag_in = 1'b0;
      end else if (ctrl.advance) begin
         // shorter prefix matched one symbol ago and this symbol agrees
         flag_in = enable & chain_in & ~(ctrl.symbol ^ pattern_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign flag_out = flag_ff;

endmodule

FILE: rtl/core/kbpm_group_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbpm_group_enc
// highest set flag within one group of cells
// ----------------------------------------------------------------------------
module kbpm_group_enc (
   input  logic [kbpm_pkg::GROUP_W-1:0] flags,
   output logic                         any,
   output logic [kbpm_pkg::POS_W-1:0]   pos
);
   import kbpm_pkg::*;

   always_comb begin
      any = |flags;
      pos = '0;
      for (int i = 0; i < GROUP_W; i++) begin
         if (flags[i]) begin
            pos = POS_W'(i);
         end
      end
   end

endmodule

FILE: rtl/core/kmp_binary_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_binary_pattern_matcher
// streaming matcher of a configured binary pattern over a text of symbols,
// overlapping occurrences reported, longest matching prefix given per symbol
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  req_symbol, req_restart
//  rsp       out        rsp_valid/rsp_ready  rsp_match, rsp_match_length, rsp_found
//  csr       in         csr_we               csr_index, csr_wdata
//
//  a transfer updates the cell row; the input stays closed until the row flags
//  move into the encoder stage, so a new symbol waits for the last to leave the row
//  the result passes the encoder stage and is held in an output register
//  a stalled output fills the encoder stage, then the input stops
//  synchronous reset: empty pipeline, no prefix matched, found cleared,
//  pattern 0 of length 1; no build pass, symbols are taken at once
//  csr write clears the matched prefix, keeps the found flag
// ----------------------------------------------------------------------------
module kmp_binary_pattern_matcher (
   input  logic                            clock,
   input  logic                            reset,
   // symbol input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_symbol,
   input  logic                            req_restart,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_match,
   output logic [kbpm_pkg::LEN_W-1:0]      rsp_match_length,
   output logic                            rsp_found,
   // configuration
   input  logic                            csr_we,
   input  logic [kbpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kbpm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kbpm_pkg::*;

   // configuration registers
   logic [PAT_W-1:0] pat_ff, pat_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] eff_len;

   // cell row
   kbpm_cell_ctrl_type     cell_ctrl;
   logic [MAX_PATTERN-1:0] cell_en;
   logic [MAX_PATTERN-1:0] cell_chain;
   logic [MAX_PATTERN-1:0] cell_flag;
   logic [FLAGS_PAD-1:0]   flags_pad;

   // handshake and pipeline control
   logic req_xfer;
   logic pend_ff, pend_in;
   logic pend_restart_ff, pend_restart_in;
   logic s1_valid_ff, s1_valid_in;
   logic s1_restart_ff, s1_restart_in;
   logic s1_move;
   logic pend_move;

   // encoder stage
   logic [GROUPS-1:0]            grp_any;
   logic [GROUPS-1:0][POS_W-1:0] grp_pos;
   logic [GROUPS-1:0]            s1_any_ff, s1_any_in;
   logic [GROUPS-1:0][POS_W-1:0] s1_pos_ff, s1_pos_in;
   logic [LEN_W-1:0]             s1_len;
   logic                         s1_hit;

   // output register and sticky flag
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_match_ff, rsp_match_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic             found_ff, found_in;

   // ---------------------------------------------------------------- config
   always_comb begin
      pat_in = pat_ff;
      len_in = len_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PATTERN_BITS:   pat_in = csr_wdata[PAT_W-1:0];
            REG_PATTERN_LENGTH: len_in = csr_wdata[LEN_W-1:0];
            default: begin
               pat_in = pat_ff;
               len_in = len_ff;
            end
         endcase
      end
   end

   // zero acts as one, anything past the row acts as the full row
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = len_ff;
      end
   end

   // ---------------------------------------------------------------- cells
   assign req_ready = ~pend_ff;
   assign req_xfer  = req_valid & req_ready;

   assign cell_ctrl.advance = req_xfer;
   assign cell_ctrl.clear   = csr_we;
   assign cell_ctrl.symbol  = req_symbol;

   // cell k flags a matched prefix of length k+1; restart empties the history
   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         assign cell_en[k] = (LEN_W'(k) < eff_len);
         if (k == 0) begin : g_head
            assign cell_chain[k] = 1'b1;
         end else begin : g_body
            assign cell_chain[k] = cell_flag[k-1] & ~req_restart;
         end
         kbpm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .pattern_bit (pat_ff[k]),
            .enable      (cell_en[k]),
            .chain_in    (cell_chain[k]),
            .flag_out    (cell_flag[k])
         );
      end
   endgenerate

   assign flags_pad = FLAGS_PAD'(cell_flag);

   // ---------------------------------------------------------------- encode
   genvar g;
   generate
      for (g = 0; g < GROUPS; g++) begin : g_grp
         kbpm_group_enc u_enc (
            .flags (flags_pad[g*GROUP_W +: GROUP_W]),
            .any   (grp_any[g]),
            .pos   (grp_pos[g])
         );
      end
   endgenerate

   assign s1_move   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign pend_move = pend_ff & (~s1_valid_ff | s1_move);

   always_comb begin
      pend_in         = pend_ff;
      pend_restart_in = pend_restart_ff;
      if (req_xfer) begin
         pend_in         = 1'b1;
         pend_restart_in = req_restart;
      end else if (pend_move) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_restart_in = s1_restart_ff;
      s1_any_in     = s1_any_ff;
      s1_pos_in     = s1_pos_ff;
      if (pend_move) begin
         s1_valid_in   = 1'b1;
         s1_restart_in = pend_restart_ff;
         s1_any_in     = grp_any;
         s1_pos_in     = grp_pos;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // highest group with a set flag gives the longest prefix
   always_comb begin
      s1_len = '0;
      for (int i = 0; i < GROUPS; i++) begin
         if (s1_any_ff[i]) begin
            s1_len = LEN_W'(i * GROUP_W) + LEN_W'(s1_pos_ff[i]) + LEN_W'(1);
         end
      end
   end

   assign s1_hit = (s1_len == eff_len);

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      rsp_len_in   = rsp_len_ff;
      found_in     = found_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = s1_hit;
         rsp_len_in   = s1_len;
         found_in     = (found_ff & ~s1_restart_ff) | s1_hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         len_ff       <= LEN_W'(1);
         pend_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pend_restart_ff <= pend_restart_in;
      s1_restart_ff   <= s1_restart_in;
      s1_any_ff       <= s1_any_in;
      s1_pos_ff       <= s1_pos_in;
      rsp_match_ff    <= rsp_match_in;
      rsp_len_ff      <= rsp_len_in;
   end

   // sticky flag only moves together with the output register
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match        = rsp_match_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_found        = found_ff;

`ifndef NO_ASSERTIONS
   a_xfer_sets_pend: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> pend_ff)
      else $error("input transfer did not mark an item in flight");

   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> rsp_found)
      else $error("match reported without found flag");

   a_match_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> (rsp_match_length == eff_len))
      else $error("match reported with a short prefix length");

   a_csr_clears_row: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (cell_flag == '0))
      else $error("cell row not cleared by a configuration write");

   a_row_within_length: assert property (@(posedge clock) disable iff (reset)
      (cell_flag & ~cell_en) == '0)
      else $error("cell beyond the pattern length is set");
`endif

endmodule
